FILE: sv/gmcp_pkg.sv
// ----------------------------------------------------------------------------
// gmcp_pkg
// shared widths, register indexes and the cell tag of the min-cost path core
// ----------------------------------------------------------------------------
package gmcp_pkg;

    localparam int COST_W     = 16;
    localparam int SUM_W      = 28;
    localparam int OUT_W      = 27;
    localparam int CFG_W      = 11;
    localparam int CFG_IDX_W  = 1;

    localparam int DEF_MAX_ROWS = 1024;
    localparam int DEF_MAX_COLS = 1024;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 1'd1;

    // what the update stage needs to know about one cell
    typedef struct packed {
        logic                     first_row;
        logic                     first_col;
        logic                     last_cell;
        logic signed [COST_W-1:0] cost;
    } cell_tag_t;

endpackage

FILE: sv/gmcp_if.sv
// ----------------------------------------------------------------------------
// gmcp_if
// valid/ready channels for cell costs and path results
// ----------------------------------------------------------------------------
interface gmcp_cost_if;
    logic                              valid;
    logic                              ready;
    logic signed [gmcp_pkg::COST_W-1:0] cell_cost;

    modport source (output valid, output cell_cost, input ready);
    modport sink   (input valid, input cell_cost, output ready);
endinterface

interface gmcp_result_if;
    logic                             valid;
    logic                             ready;
    logic signed [gmcp_pkg::OUT_W-1:0] min_cost;

    modport source (output valid, output min_cost, input ready);
    modport sink   (input valid, input min_cost, output ready);
endinterface

FILE: sv/grid_min_cost_path_core.sv
// ----------------------------------------------------------------------------
// grid_min_cost_path_core
// least cost of a right/down/diagonal path through a cost grid streamed in
// row-major order, with one row of partial sums held in a block memory
// ----------------------------------------------------------------------------
//  channel      dir  payload                 transfer
//  cost_in      in   cell_cost  s16          valid && ready
//  result_out   out  min_cost   s27          valid && ready
//  cfg          in   cfg_index, cfg_wdata    cfg_we
//
//  one cell per cycle unless the update stage is held; the row buffer read and
//  write-back each take one memory port, with the read registered ahead of the add and minimum
//  the result of the last cell goes through the update stage into the output register
//  reset clears counters and handshake state; grid size resets to 1 x 1
//  a stalled result holds the update stage only on a last cell
// ----------------------------------------------------------------------------
module grid_min_cost_path_core #(
    parameter int MAX_ROWS = gmcp_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = gmcp_pkg::DEF_MAX_COLS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    gmcp_cost_if.sink                      cost_in,
    gmcp_result_if.source                  result_out,
    input  logic                           cfg_we,
    input  logic [gmcp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gmcp_pkg::CFG_W-1:0]     cfg_wdata
);
    import gmcp_pkg::*;

    localparam int COL_AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    logic                    xfer, take_ok;
    logic [COL_AW-1:0]       iss_addr, wr_addr;
    cell_tag_t               iss_tag;
    logic signed [SUM_W-1:0] rd_data, wr_data;
    logic                    wr_en;

    assign cost_in.ready = take_ok;
    assign xfer          = cost_in.valid && take_ok;

    gmcp_scan_ctrl #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS),
        .COL_AW   (COL_AW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .xfer      (xfer),
        .cost      (cost_in.cell_cost),
        .iss_addr  (iss_addr),
        .iss_tag   (iss_tag)
    );

    gmcp_row_mem #(
        .DEPTH (MAX_COLS),
        .AW    (COL_AW)
    ) u_mem (
        .clk     (clk),
        .rd_en   (xfer),
        .rd_addr (iss_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    gmcp_cell_update #(
        .COL_AW (COL_AW)
    ) u_update (
        .clk       (clk),
        .rst_n     (rst_n),
        .iss_valid (xfer),
        .iss_addr  (iss_addr),
        .iss_tag   (iss_tag),
        .take_ok   (take_ok),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .result    (result_out)
    );

endmodule

FILE: sv/gmcp_row_mem.sv
// ----------------------------------------------------------------------------
// gmcp_row_mem
// one row of partial sums, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module gmcp_row_mem #(
    parameter int DEPTH = gmcp_pkg::DEF_MAX_COLS,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                                clk,
    input  logic                                rd_en,
    input  logic [AW-1:0]                       rd_addr,
    output logic signed [gmcp_pkg::SUM_W-1:0]   rd_data,
    input  logic                                wr_en,
    input  logic [AW-1:0]                       wr_addr,
    input  logic signed [gmcp_pkg::SUM_W-1:0]   wr_data
);
    import gmcp_pkg::*;

    logic signed [SUM_W-1:0] mem [DEPTH];
    logic signed [SUM_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/gmcp_scan_ctrl.sv
// ----------------------------------------------------------------------------
// gmcp_scan_ctrl
// grid size registers, row/column counters and row buffer read issue
// ----------------------------------------------------------------------------
module gmcp_scan_ctrl #(
    parameter int MAX_ROWS = gmcp_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = gmcp_pkg::DEF_MAX_COLS,
    parameter int COL_AW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [gmcp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [gmcp_pkg::CFG_W-1:0]           cfg_wdata,
    input  logic                                 xfer,
    input  logic signed [gmcp_pkg::COST_W-1:0]   cost,
    output logic [COL_AW-1:0]                    iss_addr,
    output gmcp_pkg::cell_tag_t                  iss_tag
);
    import gmcp_pkg::*;

    localparam int ROW_AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int ROW_CW = $clog2(MAX_ROWS + 1);
    localparam int COL_CW = $clog2(MAX_COLS + 1);

    logic [CFG_W-1:0]  grid_rows_reg, grid_rows_next;
    logic [CFG_W-1:0]  grid_cols_reg, grid_cols_next;
    logic [ROW_AW-1:0] row_reg, row_next;
    logic [COL_AW-1:0] col_reg, col_next;
    logic [ROW_CW-1:0] rows_eff, row_plus;
    logic [COL_CW-1:0] cols_eff, col_plus;
    logic              last_col, last_row;

    // zero acts as one, anything above the maximum as the maximum
    always_comb
    begin
        if (grid_rows_reg == '0)
            rows_eff = ROW_CW'(1);
        else if (32'(grid_rows_reg) > 32'(MAX_ROWS))
            rows_eff = ROW_CW'(MAX_ROWS);
        else
            rows_eff = ROW_CW'(grid_rows_reg);

        if (grid_cols_reg == '0)
            cols_eff = COL_CW'(1);
        else if (32'(grid_cols_reg) > 32'(MAX_COLS))
            cols_eff = COL_CW'(MAX_COLS);
        else
            cols_eff = COL_CW'(grid_cols_reg);
    end

    assign row_plus = ROW_CW'({1'b0, row_reg}) + ROW_CW'(1);
    assign col_plus = COL_CW'({1'b0, col_reg}) + COL_CW'(1);
    assign last_col = (col_plus == cols_eff);
    assign last_row = (row_plus == rows_eff);

    always_comb
    begin
        grid_rows_next = grid_rows_reg;
        grid_cols_next = grid_cols_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_GRID_ROWS: grid_rows_next = cfg_wdata;
                CFG_GRID_COLS: grid_cols_next = cfg_wdata;
                default:       grid_rows_next = grid_rows_reg;
            endcase
            // any size write drops the grid in progress
            row_next = '0;
            col_next = '0;
        end
        else if (xfer)
        begin
            if (!last_col)
                col_next = col_reg + COL_AW'(1);
            else
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + ROW_AW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_rows_reg <= CFG_W'(1);
            grid_cols_reg <= CFG_W'(1);
            row_reg       <= '0;
            col_reg       <= '0;
        end
        else
        begin
            grid_rows_reg <= grid_rows_next;
            grid_cols_reg <= grid_cols_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
        end
    end

    assign iss_addr          = col_reg;
    assign iss_tag.first_row = (row_reg == '0);
    assign iss_tag.first_col = (col_reg == '0);
    assign iss_tag.last_cell = last_col && last_row;
    assign iss_tag.cost      = cost;

`ifndef SYNTH
    a_col_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        COL_CW'({1'b0, col_reg}) < cols_eff)
        else $error("column counter beyond grid width");

    a_row_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        ROW_CW'({1'b0, row_reg}) < rows_eff)
        else $error("row counter beyond grid height");

    a_wrap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        xfer && iss_tag.last_cell && !cfg_we |=> row_reg == '0 && col_reg == '0)
        else $error("counters did not wrap after the last cell");
`endif

endmodule

FILE: sv/gmcp_cell_update.sv
// ----------------------------------------------------------------------------
// gmcp_cell_update
// adds the cell cost to the least neighbour sum, writes the row buffer back
// and holds the result register
// ----------------------------------------------------------------------------
module gmcp_cell_update #(
    parameter int COL_AW = $clog2(gmcp_pkg::DEF_MAX_COLS)
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               iss_valid,
    input  logic [COL_AW-1:0]                  iss_addr,
    input  gmcp_pkg::cell_tag_t                iss_tag,
    output logic                               take_ok,
    input  logic signed [gmcp_pkg::SUM_W-1:0]  rd_data,
    output logic                               wr_en,
    output logic [COL_AW-1:0]                  wr_addr,
    output logic signed [gmcp_pkg::SUM_W-1:0]  wr_data,
    gmcp_result_if.source                      result
);
    import gmcp_pkg::*;

    logic                    s1_valid_reg, s1_valid_next;
    cell_tag_t               s1_tag_reg;
    logic [COL_AW-1:0]       s1_addr_reg;
    logic                    fwd_reg, fwd_next;
    logic signed [SUM_W-1:0] fwd_data_reg;
    logic signed [SUM_W-1:0] left_reg;
    logic signed [SUM_W-1:0] diag_reg;
    logic                    out_valid_reg, out_valid_next;
    logic signed [OUT_W-1:0] min_cost_reg;

    logic                    s1_fire;
    logic signed [SUM_W-1:0] up_sum, base_sum, min_lu, sum;

    // stage only waits when its result cannot be placed
    assign s1_fire = s1_valid_reg &&
                     (!s1_tag_reg.last_cell || !out_valid_reg || result.ready);
    assign take_ok = !s1_valid_reg || s1_fire;

    // a read issued while the same entry is written returns stale data
    assign up_sum = fwd_reg ? fwd_data_reg : rd_data;
    assign min_lu = (left_reg < up_sum) ? left_reg : up_sum;

    always_comb
    begin
        priority if (s1_tag_reg.first_row && s1_tag_reg.first_col)
            base_sum = '0;
        else if (s1_tag_reg.first_row)
            base_sum = left_reg;
        else if (s1_tag_reg.first_col)
            base_sum = up_sum;
        else
            base_sum = (diag_reg < min_lu) ? diag_reg : min_lu;
    end

    assign sum = base_sum + SUM_W'(s1_tag_reg.cost);

    assign s1_valid_next  = iss_valid ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_reg);
    // forward flag belongs to the cell in the stage and leaves with it
    assign fwd_next       = iss_valid ? (s1_fire && (s1_addr_reg == iss_addr)) :
                                        (fwd_reg && !s1_fire);
    assign out_valid_next = (s1_fire && s1_tag_reg.last_cell) ? 1'b1 :
                            (result.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            fwd_reg       <= fwd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (iss_valid)
        begin
            s1_tag_reg   <= iss_tag;
            s1_addr_reg  <= iss_addr;
            fwd_data_reg <= sum;
        end
        if (s1_fire)
        begin
            left_reg <= sum;
            diag_reg <= up_sum;
        end
        if (s1_fire && s1_tag_reg.last_cell)
        begin
            min_cost_reg <= sum[OUT_W-1:0];
        end
    end

    assign wr_en           = s1_fire;
    assign wr_addr         = s1_addr_reg;
    assign wr_data         = sum;
    assign result.valid    = out_valid_reg;
    assign result.min_cost = min_cost_reg;

`ifndef SYNTH
    a_fwd_has_cell: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_reg |-> s1_valid_reg)
        else $error("forward flag set with no cell in the update stage");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        iss_valid |-> take_ok)
        else $error("cell issued into a stalled update stage");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !result.ready |=> out_valid_reg && $stable(min_cost_reg))
        else $error("pending result lost or changed");

    a_stall_keeps_cell: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_fire |=> s1_valid_reg && $stable(s1_addr_reg))
        else $error("stalled cell dropped");
`endif

endmodule

FILE: tb/gmcp_checker.sv
// ----------------------------------------------------------------------------
// gmcp_checker
// watches the cost, result and register ports of the min-cost path core,
// rebuilds the row of partial sums and checks every path cost it returns
// ----------------------------------------------------------------------------
module gmcp_checker
    import gmcp_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    gmcp_cost_if                 cost_mon,
    gmcp_result_if               result_mon,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    output int                   fail_count,
    output int                   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [CFG_W-1:0]        rows_reg;
    logic [CFG_W-1:0]        cols_reg;
    logic signed [SUM_W-1:0] upper_sums [MAX_COLS];
    logic signed [SUM_W-1:0] left_sum;
    logic signed [SUM_W-1:0] diag_sum;
    int unsigned             col_pos;
    int unsigned             row_pos;
    logic signed [OUT_W-1:0] path_costs_due [$];

    // zero acts as one, anything past the buffer acts as the largest size
    function automatic int unsigned grid_size(logic [CFG_W-1:0] value, int unsigned largest);
        if (value == '0)
            return 1;
        if (value > largest)
            return largest;
        return value;
    endfunction

    task automatic report_mismatch(string what);
        $display("checker: %s at %0t", what, $realtime);
        fail_count++;
    endtask

    task automatic add_cell(logic signed [COST_W-1:0] cost);
        int unsigned             rows;
        int unsigned             cols;
        int unsigned             c;
        int unsigned             r;
        logic signed [SUM_W-1:0] up;
        logic signed [SUM_W-1:0] best;
        logic signed [SUM_W-1:0] sum;
        rows = grid_size(rows_reg, MAX_ROWS);
        cols = grid_size(cols_reg, MAX_COLS);
        c = (col_pos >= cols) ? 0 : col_pos;
        r = (row_pos >= rows) ? 0 : row_pos;
        up = (r > 0) ? upper_sums[c] : '0;
        if (r == 0 && c == 0)
            best = '0;
        else if (r == 0)
            best = left_sum;
        else if (c == 0)
            best = up;
        else
        begin
            best = left_sum;
            if (up < best)
                best = up;
            if (diag_sum < best)
                best = diag_sum;
        end
        sum = best + cost;
        diag_sum = up;
        upper_sums[c] = sum;
        left_sum = sum;
        if (c + 1 < cols)
        begin
            col_pos = c + 1;
            row_pos = r;
        end
        else
        begin
            col_pos = 0;
            if (r + 1 < rows)
                row_pos = r + 1;
            else
            begin
                row_pos = 0;
                left_sum = '0;
                diag_sum = '0;
                path_costs_due.push_back(sum[OUT_W-1:0]);
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rows_reg = 1;
            cols_reg = 1;
            left_sum = '0;
            diag_sum = '0;
            col_pos = 0;
            row_pos = 0;
            path_costs_due.delete();
            fail_count = 0;
        end
        else
        begin
            // any size write starts a fresh grid
            if (cfg_we)
            begin
                if (cfg_index == CFG_GRID_ROWS)
                    rows_reg = cfg_wdata;
                else if (cfg_index == CFG_GRID_COLS)
                    cols_reg = cfg_wdata;
                col_pos = 0;
                row_pos = 0;
                left_sum = '0;
                diag_sum = '0;
            end
            if (cost_mon.valid && cost_mon.ready)
                add_cell(cost_mon.cell_cost);
            if (result_mon.valid && result_mon.ready)
            begin
                if (path_costs_due.size() == 0)
                    report_mismatch($sformatf("min_cost %0d with no grid completed",
                                              result_mon.min_cost));
                else
                begin
                    logic signed [OUT_W-1:0] due;
                    due = path_costs_due.pop_front();
                    if (result_mon.min_cost !== due)
                        report_mismatch($sformatf("min_cost %0d, expected %0d",
                                                  result_mon.min_cost, due));
                end
            end
        end
        pending = path_costs_due.size();
    end

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// streams cost grids of many sizes into the min-cost path core, with random
// gaps and result back-pressure, and leaves the checking to gmcp_checker
// ----------------------------------------------------------------------------
module testbench;
    import gmcp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;
    int                   fail_count;
    int                   pending;
    bit                   tx_gaps;
    bit                   rx_stalls;
    int                   rx_hold;
    int                   cells_sent;
    int                   cur_rows;
    int                   cur_cols;

    gmcp_cost_if   cost_ch ();
    gmcp_result_if result_ch ();

    grid_min_cost_path_core u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cost_in    (cost_ch),
        .result_out (result_ch),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata)
    );

    gmcp_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cost_mon   (cost_ch),
        .result_mon (result_ch),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #4 clk = ~clk;

    initial
    begin
        #40_000_000;
        $display("tb: failure");
        $finish;
    end

    // mostly back-to-back, now and then a short gap, rarely a long one
    function automatic int gap_len(bit enabled);
        int pick;
        if (!enabled)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 3);
        if (pick < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [COST_W-1:0] random_cost();
        case ($urandom_range(0, 9))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2, 3: return COST_W'(int'($urandom_range(0, 64)) - 32);
            default: return COST_W'($urandom());
        endcase
    endfunction

    function automatic int random_dim();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            return 0;
        if (pick < 13)
            return $urandom_range(1, 5);
        if (pick < 18)
            return $urandom_range(6, 16);
        return $urandom_range(17, 32);
    endfunction

    always @(negedge clk)
    begin
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else if (rx_hold > 0)
        begin
            result_ch.ready <= 1'b0;
            rx_hold--;
        end
        else
        begin
            result_ch.ready <= 1'b1;
            rx_hold = gap_len(rx_stalls);
        end
    end

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic push_cell(logic signed [COST_W-1:0] cost);
        int gap;
        gap = gap_len(tx_gaps);
        if (gap > 0)
        begin
            cost_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cost_ch.valid <= 1'b1;
        cost_ch.cell_cost <= cost;
        @(posedge clk);
        while (!cost_ch.ready)
            @(posedge clk);
        @(negedge clk);
        cells_sent++;
    endtask

    task automatic push_cells(int count);
        repeat (count) push_cell(random_cost());
    endtask

    // drain every outstanding path cost, then give the pipeline time to empty
    task automatic settle();
        cost_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (16) @(negedge clk);
    endtask

    task automatic write_size(bit set_rows, bit set_cols, int rows, int cols);
        if (set_rows)
        begin
            cfg_we <= 1'b1;
            cfg_index <= CFG_GRID_ROWS;
            cfg_wdata <= CFG_W'(rows);
            cur_rows = (rows == 0) ? 1 : ((rows > DEF_MAX_ROWS) ? DEF_MAX_ROWS : rows);
            @(negedge clk);
        end
        if (set_cols)
        begin
            cfg_we <= 1'b1;
            cfg_index <= CFG_GRID_COLS;
            cfg_wdata <= CFG_W'(cols);
            cur_cols = (cols == 0) ? 1 : ((cols > DEF_MAX_COLS) ? DEF_MAX_COLS : cols);
            @(negedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        logic signed [COST_W-1:0] diag_route [6];
        int total;
        diag_route = '{16'sd1, 16'sd9, 16'sd9, 16'sd9, 16'sd1, 16'sd1};
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_GRID_ROWS;
        cfg_wdata = '0;
        cost_ch.valid = 1'b0;
        cost_ch.cell_cost = '0;
        result_ch.ready = 1'b0;
        tx_gaps = 1'b0;
        rx_stalls = 1'b0;
        rx_hold = 0;
        cells_sent = 0;
        cur_rows = 1;
        cur_cols = 1;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // single-cell grids at the reset size, cost extremes
        push_cell(16'sh7fff);
        push_cell(16'sh8000);
        push_cell(16'sh0000);
        push_cell(16'shffff);
        settle();
        write_size(1, 1, 0, 0);
        push_cell(16'sh5a5a);
        // cheapest route runs along the diagonal
        settle();
        write_size(1, 1, 2, 3);
        foreach (diag_route[i])
            push_cell(diag_route[i]);
        settle();
        write_size(1, 1, 3, 2);
        repeat (6) push_cell(16'sh8000);
        settle();
        write_size(1, 1, 1, 4);
        repeat (4) push_cell(16'sh7fff);

        // counter limits, with a register value past the widest grid
        settle();
        tx_gaps = 1'b1;
        rx_stalls = 1'b1;
        write_size(1, 1, 1, 2047);
        push_cells(cur_rows * cur_cols);

        while (cells_sent < 1900)
        begin
            settle();
            tx_gaps = ($urandom_range(0, 3) != 0);
            rx_stalls = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 5))
                0: write_size(1, 0, random_dim(), 0);
                1: write_size(0, 1, 0, random_dim());
                default: write_size(1, 1, random_dim(), random_dim());
            endcase
            total = cur_rows * cur_cols;
            repeat ($urandom_range(1, 4)) push_cells(total);
            // leave a grid unfinished so the next size write has to drop it
            if (total > 1 && $urandom_range(0, 7) == 0)
                push_cells($urandom_range(1, total - 1));
        end

        settle();
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: files.f
sv/gmcp_pkg.sv
sv/gmcp_if.sv
sv/gmcp_row_mem.sv
sv/gmcp_scan_ctrl.sv
sv/gmcp_cell_update.sv
sv/grid_min_cost_path_core.sv
tb/gmcp_checker.sv
tb/testbench.sv
